>>> rtl/core/atpd_pkg.sv
// Shared types and constants for the ARM/Thumb instruction predecoder.
// Holds the fetch and decode transaction structs, operation codes and attribute bits.
// No dependencies; every other file of the block imports this package.
package atpd_pkg;

	typedef struct packed {
		logic [31:0] fetch_address;
		logic [31:0] instruction_word;
		logic        thumb_mode;
	} fetch_t;

	typedef struct packed {
		logic [5:0]  operation;
		logic [3:0]  condition;
		logic        always_executes;
		logic [3:0]  dest_reg;
		logic [3:0]  first_reg;
		logic [3:0]  second_reg;
		logic [3:0]  shift_reg;
		logic [31:0] immediate;
		logic [1:0]  shift_kind;
		logic [4:0]  shift_amount;
		logic [3:0]  attributes;
		logic [31:0] next_address;
	} decode_t;

	// Attribute bit positions.
	localparam int ATTR_WPC   = 0;
	localparam int ATTR_FLAGS = 1;
	localparam int ATTR_SREG  = 2;
	localparam int ATTR_IMM   = 3;

	// Dense operation codes. Codes 0 to 15 are the ARM data processing opcodes.
	localparam logic [5:0] OP_AND      = 6'd0;
	localparam logic [5:0] OP_EOR      = 6'd1;
	localparam logic [5:0] OP_SUB      = 6'd2;
	localparam logic [5:0] OP_ADD      = 6'd4;
	localparam logic [5:0] OP_ADC      = 6'd5;
	localparam logic [5:0] OP_SBC      = 6'd6;
	localparam logic [5:0] OP_TST      = 6'd8;
	localparam logic [5:0] OP_CMP      = 6'd10;
	localparam logic [5:0] OP_CMN      = 6'd11;
	localparam logic [5:0] OP_ORR      = 6'd12;
	localparam logic [5:0] OP_MOV      = 6'd13;
	localparam logic [5:0] OP_BIC      = 6'd14;
	localparam logic [5:0] OP_MVN      = 6'd15;
	localparam logic [5:0] OP_MUL      = 6'd16;
	localparam logic [5:0] OP_MLA      = 6'd17;
	localparam logic [5:0] OP_UMULL    = 6'd18;
	localparam logic [5:0] OP_B        = 6'd22;
	localparam logic [5:0] OP_BL       = 6'd23;
	localparam logic [5:0] OP_BX       = 6'd24;
	localparam logic [5:0] OP_BLX_REG  = 6'd25;
	localparam logic [5:0] OP_BLX_IMM  = 6'd26;
	localparam logic [5:0] OP_SVC      = 6'd27;
	localparam logic [5:0] OP_LDR      = 6'd28;
	localparam logic [5:0] OP_LDRB     = 6'd29;
	localparam logic [5:0] OP_STR      = 6'd30;
	localparam logic [5:0] OP_STRB     = 6'd31;
	localparam logic [5:0] OP_LDM      = 6'd32;
	localparam logic [5:0] OP_STM      = 6'd33;
	localparam logic [5:0] OP_CLREX    = 6'd34;
	localparam logic [5:0] OP_NOP      = 6'd35;
	localparam logic [5:0] OP_CPS      = 6'd36;
	localparam logic [5:0] OP_FALLBACK = 6'd37;

	localparam logic [3:0] COND_AL = 4'd14;
	localparam logic [3:0] COND_NV = 4'd15;
	localparam logic [3:0] REG_SP  = 4'd13;
	localparam logic [3:0] REG_PC  = 4'd15;

	// Thumb format 4 ALU op to dense operation code.
	localparam logic [5:0] THUMB_ALU_MAP [16] = '{
		OP_AND, OP_EOR, OP_FALLBACK, OP_FALLBACK, OP_FALLBACK, OP_ADC, OP_SBC, OP_FALLBACK,
		OP_TST, OP_FALLBACK, OP_CMP, OP_CMN, OP_ORR, OP_MUL, OP_BIC, OP_MVN
	};

	// Load/store code from the load and byte bits.
	function automatic logic [5:0] ld_op(input logic load, input logic byte_acc);
		logic [5:0] op;
		if (load) begin
			op = byte_acc ? OP_LDRB : OP_LDR;
		end else begin
			op = byte_acc ? OP_STRB : OP_STR;
		end
		return op;
	endfunction

endpackage

>>> rtl/core/atpd_arm_dec.sv
// Combinational decoder for 32-bit ARM instruction words.
// Depends on atpd_pkg for the decode record, operation codes and attribute bits.
// The always_executes field is left zero and filled in by the top level.
module atpd_arm_dec import atpd_pkg::*; (
	input  logic [31:0] pc,
	input  logic [31:0] w,
	output decode_t     rec
);

	logic [31:0] br_off;
	logic [31:0] pc_plus8;
	logic [63:0] rot_src;
	logic [4:0]  rot;
	logic [31:0] rot_imm;
	logic [31:0] blx_sum;
	logic        is_mul;
	logic        load;

	assign br_off   = {{6{w[23]}}, w[23:0], 2'b00};
	assign pc_plus8 = pc + 32'd8;
	assign rot_src  = {24'd0, w[7:0], 24'd0, w[7:0]};
	assign rot      = {w[11:8], 1'b0};
	assign rot_imm  = rot_src[rot +: 32];
	assign blx_sum  = pc_plus8 + br_off + {30'd0, w[24], 1'b0};
	assign is_mul   = ((w & 32'h0fc000f0) == 32'h00000090) ||
	                  ((w & 32'h0f8000f0) == 32'h00800090);
	assign load     = w[20];

	always_comb begin
		rec = '0;
		rec.next_address = pc + 32'd4;
		rec.condition = w[31:28];
		if (w[31:28] == COND_NV) begin
			if (w == 32'hf57ff01f) begin
				rec.operation = OP_CLREX;
			end else if ((w & 32'h0c00f000) == 32'h0400f000) begin
				rec.operation = OP_NOP;
			end else if ((w & 32'hfe000000) == 32'hfa000000) begin
				rec.operation = OP_BLX_IMM;
				rec.immediate = {blx_sum[31:1], 1'b0};
				rec.attributes[ATTR_WPC] = 1'b1;
			end else if ((w & 32'hfff1fe20) == 32'hf1000000) begin
				rec.operation = OP_CPS;
				rec.immediate = w;
			end else begin
				rec.operation = OP_FALLBACK;
			end
		end else if (w[27:25] == 3'b101) begin
			rec.operation = w[24] ? OP_BL : OP_B;
			rec.immediate = pc_plus8 + br_off;
			rec.attributes[ATTR_WPC] = 1'b1;
		end else if (w[27:4] == 24'h12fff1) begin
			rec.operation = OP_BX;
			rec.second_reg = w[3:0];
			rec.attributes[ATTR_WPC] = 1'b1;
		end else if (w[27:4] == 24'h12fff3) begin
			rec.operation = OP_BLX_REG;
			rec.second_reg = w[3:0];
			rec.attributes[ATTR_WPC] = 1'b1;
		end else if (w[27:24] == 4'hf) begin
			rec.operation = OP_SVC;
			rec.immediate = {8'd0, w[23:0]};
			rec.attributes[ATTR_WPC] = 1'b1;
		end else if (w[27:26] == 2'b00) begin
			if (is_mul) begin
				if (w[23]) begin
					rec.operation = OP_UMULL + {4'd0, w[22], w[21]};
				end else begin
					rec.operation = w[21] ? OP_MLA : OP_MUL;
				end
				rec.attributes[ATTR_FLAGS] = w[20];
				rec.dest_reg   = w[19:16];
				rec.first_reg  = w[15:12];
				rec.shift_reg  = w[11:8];
				rec.second_reg = w[3:0];
				rec.attributes[ATTR_WPC] = (w[19:16] == REG_PC) ||
				                           (w[23] && (w[15:12] == REG_PC));
			end else if ((w & 32'h0e000090) == 32'h00000090) begin
				rec.operation = OP_FALLBACK;
			end else begin
				rec.operation = {2'b00, w[24:21]};
				rec.attributes[ATTR_FLAGS] = w[20];
				rec.first_reg = w[19:16];
				rec.dest_reg  = w[15:12];
				rec.attributes[ATTR_WPC] = (w[15:12] == REG_PC);
				rec.attributes[ATTR_IMM] = w[25];
				if (w[25]) begin
					rec.immediate = rot_imm;
				end else begin
					rec.second_reg = w[3:0];
					rec.attributes[ATTR_SREG] = w[4];
					rec.shift_kind = w[6:5];
					if (w[4]) begin
						rec.shift_reg = w[11:8];
					end else begin
						rec.shift_amount = w[11:7];
					end
				end
			end
		end else if (w[27:26] == 2'b01) begin
			rec.first_reg = w[19:16];
			rec.dest_reg  = w[15:12];
			rec.attributes[ATTR_WPC] = load && (w[15:12] == REG_PC);
			if (!w[25] && w[24] && !w[21]) begin
				rec.operation = ld_op(load, w[22]);
				rec.immediate = w[23] ? {20'd0, w[11:0]} : (32'd0 - {20'd0, w[11:0]});
				rec.attributes[ATTR_IMM] = 1'b1;
			end else begin
				rec.operation = OP_FALLBACK;
			end
		end else if (w[27:25] == 3'b100) begin
			rec.operation = w[22] ? OP_FALLBACK : (load ? OP_LDM : OP_STM);
			rec.first_reg = w[19:16];
			rec.immediate = {16'd0, w[15:0]};
			rec.attributes[ATTR_WPC] = load && w[15];
		end else begin
			rec.operation = OP_FALLBACK;
		end
	end

endmodule

>>> rtl/core/atpd_thumb_dec.sv
// Combinational decoder for 16-bit Thumb instruction halfwords.
// Depends on atpd_pkg for the decode record, operation codes and the ALU map.
// The always_executes field is left zero and filled in by the top level.
module atpd_thumb_dec import atpd_pkg::*; (
	input  logic [31:0] pc,
	input  logic [15:0] t,
	output decode_t     rec
);

	logic [31:0] pc_plus4;
	logic [31:0] bcond_off;
	logic [31:0] b_off;
	logic [3:0]  hd;

	assign pc_plus4  = pc + 32'd4;
	assign bcond_off = {{23{t[7]}}, t[7:0], 1'b0};
	assign b_off     = {{20{t[10]}}, t[10:0], 1'b0};
	assign hd        = {t[7], t[2:0]};

	always_comb begin
		rec = '0;
		rec.next_address = pc + 32'd2;
		rec.condition = COND_AL;
		rec.attributes[ATTR_FLAGS] = 1'b1;
		if (t[15:13] == 3'b001) begin
			// Move, compare, add, subtract with an 8-bit immediate.
			rec.dest_reg  = {1'b0, t[10:8]};
			rec.first_reg = {1'b0, t[10:8]};
			rec.immediate = {24'd0, t[7:0]};
			rec.attributes[ATTR_IMM] = 1'b1;
			case (t[12:11])
				2'd0:    rec.operation = OP_MOV;
				2'd1:    rec.operation = OP_CMP;
				2'd2:    rec.operation = OP_ADD;
				default: rec.operation = OP_SUB;
			endcase
		end else if (t[15:13] == 3'b000 && t[12:11] != 2'b11) begin
			rec.dest_reg     = {1'b0, t[2:0]};
			rec.second_reg   = {1'b0, t[5:3]};
			rec.shift_amount = t[10:6];
			rec.shift_kind   = t[12:11];
			rec.operation    = OP_MOV;
		end else if (t[15:11] == 5'b00011) begin
			rec.operation = t[9] ? OP_SUB : OP_ADD;
			rec.dest_reg  = {1'b0, t[2:0]};
			rec.first_reg = {1'b0, t[5:3]};
			if (t[10]) begin
				rec.immediate = {29'd0, t[8:6]};
				rec.attributes[ATTR_IMM] = 1'b1;
			end else begin
				rec.second_reg = {1'b0, t[8:6]};
			end
		end else if (t[15:10] == 6'b010000) begin
			rec.dest_reg   = {1'b0, t[2:0]};
			rec.first_reg  = {1'b0, t[2:0]};
			rec.second_reg = {1'b0, t[5:3]};
			rec.operation  = THUMB_ALU_MAP[t[9:6]];
		end else if (t[15:10] == 6'b010001) begin
			// High register operations and branch exchange.
			rec.second_reg = t[6:3];
			case (t[9:8])
				2'd3: begin
					rec.operation = t[7] ? OP_BLX_REG : OP_BX;
					rec.attributes[ATTR_WPC] = 1'b1;
				end
				2'd2: begin
					rec.operation = OP_MOV;
					rec.dest_reg = hd;
					rec.attributes[ATTR_FLAGS] = 1'b0;
					rec.attributes[ATTR_WPC] = (hd == REG_PC);
				end
				2'd0: begin
					rec.operation = OP_ADD;
					rec.dest_reg = hd;
					rec.first_reg = hd;
					rec.attributes[ATTR_FLAGS] = 1'b0;
					rec.attributes[ATTR_WPC] = (hd == REG_PC);
				end
				default: begin
					rec.operation = OP_CMP;
					rec.first_reg = hd;
				end
			endcase
		end else if (t[15:11] == 5'b01001) begin
			rec.operation = OP_LDR;
			rec.dest_reg  = {1'b0, t[10:8]};
			rec.first_reg = REG_PC;
			rec.immediate = {22'd0, t[7:0], 2'b00};
			rec.attributes[ATTR_IMM] = 1'b1;
			rec.attributes[ATTR_FLAGS] = 1'b0;
		end else if (t[15:13] == 3'b011) begin
			rec.dest_reg  = {1'b0, t[2:0]};
			rec.first_reg = {1'b0, t[5:3]};
			rec.immediate = t[12] ? {27'd0, t[10:6]} : {25'd0, t[10:6], 2'b00};
			rec.attributes[ATTR_IMM] = 1'b1;
			rec.attributes[ATTR_FLAGS] = 1'b0;
			rec.operation = ld_op(t[11], t[12]);
		end else if (t[15:12] == 4'b1001) begin
			rec.dest_reg  = {1'b0, t[10:8]};
			rec.first_reg = REG_SP;
			rec.immediate = {22'd0, t[7:0], 2'b00};
			rec.attributes[ATTR_IMM] = 1'b1;
			rec.attributes[ATTR_FLAGS] = 1'b0;
			rec.operation = t[11] ? OP_LDR : OP_STR;
		end else if (t[15:12] == 4'b1101 && t[11:8] == COND_NV) begin
			rec.operation = OP_SVC;
			rec.immediate = {24'd0, t[7:0]};
			rec.attributes[ATTR_WPC] = 1'b1;
		end else if (t[15:12] == 4'b1101 && t[11:8] != COND_AL) begin
			rec.operation = OP_B;
			rec.condition = t[11:8];
			rec.immediate = pc_plus4 + bcond_off;
			rec.attributes[ATTR_WPC] = 1'b1;
		end else if (t[15:11] == 5'b11100) begin
			rec.operation = OP_B;
			rec.immediate = pc_plus4 + b_off;
			rec.attributes[ATTR_WPC] = 1'b1;
		end else begin
			rec.operation = OP_FALLBACK;
		end
	end

endmodule

>>> rtl/core/arm_thumb_instruction_predecoder.sv
// Top level of the ARM/Thumb instruction predecoder: input register, decode, result register.
// Depends on atpd_pkg, atpd_arm_dec and atpd_thumb_dec.
//
// Channel   Role     Handshake               Payload
// fetch     in       fetch_valid/stall       fetch_t  (address, word, Thumb flag)
// decode    out      decode_valid/stall      decode_t (predecoded record)
//
// A transaction accepted into the input register is decoded from it combinationally and
// lands in the result register once that register is empty or being read, which raises
// decode_valid. Both stages advance every cycle the result side is not stalled,
// so one fetch transaction is accepted per cycle. An empty input stage is filled even while
// a finished result waits, so fetch_stall rises only when both stages hold transactions and
// decode is stalled. Reset clears the two valid flags; payload registers are not reset.
module arm_thumb_instruction_predecoder import atpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fetch_valid,
	output logic    fetch_stall,
	input  fetch_t  fetch,
	output logic    decode_valid,
	input  logic    decode_stall,
	output decode_t decode
);

	logic    valid_s1;
	fetch_t  fetch_s1;
	logic    valid_s2;
	decode_t decode_s2;
	logic    load_s1;
	logic    load_s2;
	decode_t arm_rec;
	decode_t thumb_rec;
	decode_t rec;

	// The result register takes a new value when it is empty or its value is being taken.
	assign load_s2     = !valid_s2 || !decode_stall;
	assign load_s1     = !valid_s1 || load_s2;
	assign fetch_stall = !load_s1;

	atpd_arm_dec u_arm_dec (
		.pc  (fetch_s1.fetch_address),
		.w   (fetch_s1.instruction_word),
		.rec (arm_rec)
	);

	atpd_thumb_dec u_thumb_dec (
		.pc  (fetch_s1.fetch_address),
		.t   (fetch_s1.instruction_word[15:0]),
		.rec (thumb_rec)
	);

	// Pick the decoder for the mode and mark unconditional execution.
	always_comb begin
		rec = fetch_s1.thumb_mode ? thumb_rec : arm_rec;
		rec.always_executes = (rec.condition == COND_AL) || (rec.condition == COND_NV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= fetch_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && fetch_valid) begin
			fetch_s1 <= fetch;
		end
		if (load_s2 && valid_s1) begin
			decode_s2 <= rec;
		end
	end

	assign decode_valid = valid_s2;
	assign decode       = decode_s2;

endmodule

>>> bench/predecode_checker.sv
// Checker for the ARM/Thumb instruction predecoder: watches the fetch and decode channels,
// predicts each decode record from the accepted fetch and compares it field by field.
// Depends on atpd_pkg for the transaction structs, operation codes and attribute bits.
`timescale 1ns / 100ps

module predecode_checker import atpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fetch_valid,
	input  logic    fetch_stall,
	input  fetch_t  fetch,
	input  logic    decode_valid,
	input  logic    decode_stall,
	input  decode_t decode,
	output int      mismatches,
	output int      pending
);

	localparam int          MAX_REPORTS = 10;
	localparam logic [31:0] CLREX_WORD  = 32'hf57ff01f;

	decode_t expected_decodes[$];
	int      error_count;

	function automatic logic [5:0] transfer_op(input logic is_load, input logic is_byte);
		logic [5:0] op;
		case ({is_load, is_byte})
			2'b11: op = OP_LDRB;
			2'b10: op = OP_LDR;
			2'b01: op = OP_STRB;
			default: op = OP_STR;
		endcase
		return op;
	endfunction

	function automatic decode_t predict_decode(input fetch_t f);
		decode_t     d;
		logic [31:0] pc;
		logic [31:0] w;
		logic [15:0] t;
		logic [31:0] branch_ofs;
		logic [63:0] rot_pair;
		logic [3:0]  hi_reg;
		logic        is_long;
		d = '0;
		pc = f.fetch_address;
		w = f.instruction_word;
		t = w[15:0];
		if (!f.thumb_mode) begin
			d.next_address = pc + 32'd4;
			d.condition = w[31:28];
			branch_ofs = {{6{w[23]}}, w[23:0], 2'b00};
			if (w[31:28] == COND_NV) begin
				if (w == CLREX_WORD) begin
					d.operation = OP_CLREX;
				end else if ((w & 32'h0c00f000) == 32'h0400f000) begin
					d.operation = OP_NOP;
				end else if (w[27:25] == 3'b101) begin
					d.operation = OP_BLX_IMM;
					d.immediate = (pc + 32'd8 + branch_ofs + {30'd0, w[24], 1'b0}) & ~32'd1;
					d.attributes[ATTR_WPC] = 1'b1;
				end else if ((w & 32'hfff1fe20) == 32'hf1000000) begin
					d.operation = OP_CPS;
					d.immediate = w;
				end else begin
					d.operation = OP_FALLBACK;
				end
			end else if (w[27:25] == 3'b101) begin
				d.operation = w[24] ? OP_BL : OP_B;
				d.immediate = pc + 32'd8 + branch_ofs;
				d.attributes[ATTR_WPC] = 1'b1;
			end else if (w[27:4] == 24'h12fff1 || w[27:4] == 24'h12fff3) begin
				d.operation = (w[27:4] == 24'h12fff1) ? OP_BX : OP_BLX_REG;
				d.second_reg = w[3:0];
				d.attributes[ATTR_WPC] = 1'b1;
			end else if (w[27:24] == 4'hf) begin
				d.operation = OP_SVC;
				d.immediate = {8'd0, w[23:0]};
				d.attributes[ATTR_WPC] = 1'b1;
			end else if (w[27:26] == 2'b00) begin
				if (w[7:4] == 4'b1001 && (w[27:22] == 6'd0 || w[27:23] == 5'b00001)) begin
					is_long = w[23];
					if (is_long) begin
						d.operation = OP_UMULL + {4'd0, w[22], w[21]};
					end else begin
						d.operation = w[21] ? OP_MLA : OP_MUL;
					end
					d.attributes[ATTR_FLAGS] = w[20];
					d.dest_reg = w[19:16];
					d.first_reg = w[15:12];
					d.shift_reg = w[11:8];
					d.second_reg = w[3:0];
					d.attributes[ATTR_WPC] = (w[19:16] == REG_PC) ||
						(is_long && w[15:12] == REG_PC);
				end else if (w[27:25] == 3'b000 && w[7] && w[4]) begin
					// Halfword and other extra transfers are not decoded.
					d.operation = OP_FALLBACK;
				end else begin
					d.operation = {2'b00, w[24:21]};
					d.attributes[ATTR_FLAGS] = w[20];
					d.first_reg = w[19:16];
					d.dest_reg = w[15:12];
					d.attributes[ATTR_WPC] = (w[15:12] == REG_PC);
					d.attributes[ATTR_IMM] = w[25];
					if (w[25]) begin
						rot_pair = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
						d.immediate = rot_pair[31:0];
					end else begin
						d.second_reg = w[3:0];
						d.attributes[ATTR_SREG] = w[4];
						d.shift_kind = w[6:5];
						if (w[4]) begin
							d.shift_reg = w[11:8];
						end else begin
							d.shift_amount = w[11:7];
						end
					end
				end
			end else if (w[27:26] == 2'b01) begin
				d.first_reg = w[19:16];
				d.dest_reg = w[15:12];
				d.attributes[ATTR_WPC] = w[20] && (w[15:12] == REG_PC);
				if (!w[25] && w[24] && !w[21]) begin
					d.operation = transfer_op(w[20], w[22]);
					d.immediate = w[23] ? {20'd0, w[11:0]} : 32'd0 - {20'd0, w[11:0]};
					d.attributes[ATTR_IMM] = 1'b1;
				end else begin
					d.operation = OP_FALLBACK;
				end
			end else if (w[27:25] == 3'b100) begin
				// The user-bank form still reports base, list and PC write.
				d.operation = w[22] ? OP_FALLBACK : (w[20] ? OP_LDM : OP_STM);
				d.first_reg = w[19:16];
				d.immediate = {16'd0, w[15:0]};
				d.attributes[ATTR_WPC] = w[20] && w[15];
			end else begin
				d.operation = OP_FALLBACK;
			end
		end else begin
			d.next_address = pc + 32'd2;
			d.condition = COND_AL;
			d.attributes[ATTR_FLAGS] = 1'b1;
			if (t[15:13] == 3'b001) begin
				d.dest_reg = {1'b0, t[10:8]};
				d.first_reg = {1'b0, t[10:8]};
				d.immediate = {24'd0, t[7:0]};
				d.attributes[ATTR_IMM] = 1'b1;
				case (t[12:11])
					2'd0: d.operation = OP_MOV;
					2'd1: d.operation = OP_CMP;
					2'd2: d.operation = OP_ADD;
					default: d.operation = OP_SUB;
				endcase
			end else if (t[15:13] == 3'b000 && t[12:11] != 2'b11) begin
				d.operation = OP_MOV;
				d.dest_reg = {1'b0, t[2:0]};
				d.second_reg = {1'b0, t[5:3]};
				d.shift_amount = t[10:6];
				d.shift_kind = t[12:11];
			end else if (t[15:11] == 5'b00011) begin
				d.operation = t[9] ? OP_SUB : OP_ADD;
				d.dest_reg = {1'b0, t[2:0]};
				d.first_reg = {1'b0, t[5:3]};
				if (t[10]) begin
					d.immediate = {29'd0, t[8:6]};
					d.attributes[ATTR_IMM] = 1'b1;
				end else begin
					d.second_reg = {1'b0, t[8:6]};
				end
			end else if (t[15:10] == 6'b010000) begin
				d.dest_reg = {1'b0, t[2:0]};
				d.first_reg = {1'b0, t[2:0]};
				d.second_reg = {1'b0, t[5:3]};
				case (t[9:6])
					4'd0: d.operation = OP_AND;
					4'd1: d.operation = OP_EOR;
					4'd5: d.operation = OP_ADC;
					4'd6: d.operation = OP_SBC;
					4'd8: d.operation = OP_TST;
					4'd10: d.operation = OP_CMP;
					4'd11: d.operation = OP_CMN;
					4'd12: d.operation = OP_ORR;
					4'd13: d.operation = OP_MUL;
					4'd14: d.operation = OP_BIC;
					4'd15: d.operation = OP_MVN;
					default: d.operation = OP_FALLBACK;
				endcase
			end else if (t[15:10] == 6'b010001) begin
				hi_reg = {t[7], t[2:0]};
				d.second_reg = t[6:3];
				case (t[9:8])
					2'd3: begin
						d.operation = t[7] ? OP_BLX_REG : OP_BX;
						d.attributes[ATTR_WPC] = 1'b1;
					end
					2'd2: begin
						d.operation = OP_MOV;
						d.dest_reg = hi_reg;
						d.attributes[ATTR_FLAGS] = 1'b0;
						d.attributes[ATTR_WPC] = (hi_reg == REG_PC);
					end
					2'd0: begin
						d.operation = OP_ADD;
						d.dest_reg = hi_reg;
						d.first_reg = hi_reg;
						d.attributes[ATTR_FLAGS] = 1'b0;
						d.attributes[ATTR_WPC] = (hi_reg == REG_PC);
					end
					default: begin
						d.operation = OP_CMP;
						d.first_reg = hi_reg;
					end
				endcase
			end else if (t[15:11] == 5'b01001) begin
				d.operation = OP_LDR;
				d.dest_reg = {1'b0, t[10:8]};
				d.first_reg = REG_PC;
				d.immediate = {22'd0, t[7:0], 2'b00};
				d.attributes[ATTR_IMM] = 1'b1;
				d.attributes[ATTR_FLAGS] = 1'b0;
			end else if (t[15:13] == 3'b011) begin
				d.operation = transfer_op(t[11], t[12]);
				d.dest_reg = {1'b0, t[2:0]};
				d.first_reg = {1'b0, t[5:3]};
				d.immediate = t[12] ? {27'd0, t[10:6]} : {25'd0, t[10:6], 2'b00};
				d.attributes[ATTR_IMM] = 1'b1;
				d.attributes[ATTR_FLAGS] = 1'b0;
			end else if (t[15:12] == 4'b1001) begin
				d.operation = t[11] ? OP_LDR : OP_STR;
				d.dest_reg = {1'b0, t[10:8]};
				d.first_reg = REG_SP;
				d.immediate = {22'd0, t[7:0], 2'b00};
				d.attributes[ATTR_IMM] = 1'b1;
				d.attributes[ATTR_FLAGS] = 1'b0;
			end else if (t[15:12] == 4'b1101 && t[11:8] == COND_NV) begin
				d.operation = OP_SVC;
				d.immediate = {24'd0, t[7:0]};
				d.attributes[ATTR_WPC] = 1'b1;
			end else if (t[15:12] == 4'b1101 && t[11:8] < COND_AL) begin
				d.operation = OP_B;
				d.condition = t[11:8];
				d.immediate = pc + 32'd4 + {{23{t[7]}}, t[7:0], 1'b0};
				d.attributes[ATTR_WPC] = 1'b1;
			end else if (t[15:11] == 5'b11100) begin
				d.operation = OP_B;
				d.immediate = pc + 32'd4 + {{20{t[10]}}, t[10:0], 1'b0};
				d.attributes[ATTR_WPC] = 1'b1;
			end else begin
				d.operation = OP_FALLBACK;
			end
		end
		d.always_executes = (d.condition >= COND_AL);
		return d;
	endfunction

	function automatic string field_diff(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			return $sformatf(" %s exp=%0h got=%0h", name, want, got);
		end
		return "";
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decode_t want;
		string   diff;
		if (!arst_n) begin
			expected_decodes.delete();
			error_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// Retire first: a record accepted now was never fetched in this same cycle.
			if (decode_valid && !decode_stall) begin
				if (expected_decodes.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("%0t: decode transaction with nothing expected", $time);
					end
				end else begin
					want = expected_decodes.pop_front();
					diff = {field_diff("operation", 32'(want.operation),
							32'(decode.operation)),
						field_diff("condition", 32'(want.condition),
							32'(decode.condition)),
						field_diff("always_executes", 32'(want.always_executes),
							32'(decode.always_executes)),
						field_diff("dest_reg", 32'(want.dest_reg), 32'(decode.dest_reg)),
						field_diff("first_reg", 32'(want.first_reg),
							32'(decode.first_reg)),
						field_diff("second_reg", 32'(want.second_reg),
							32'(decode.second_reg)),
						field_diff("shift_reg", 32'(want.shift_reg),
							32'(decode.shift_reg)),
						field_diff("immediate", want.immediate, decode.immediate),
						field_diff("shift_kind", 32'(want.shift_kind),
							32'(decode.shift_kind)),
						field_diff("shift_amount", 32'(want.shift_amount),
							32'(decode.shift_amount)),
						field_diff("attributes", 32'(want.attributes),
							32'(decode.attributes)),
						field_diff("next_address", want.next_address, decode.next_address)};
					if (diff != "") begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$display("%0t: decode mismatch:%s", $time, diff);
						end
					end
				end
			end
			if (fetch_valid && !fetch_stall) begin
				expected_decodes.push_back(predict_decode(fetch));
			end
			mismatches <= error_count;
			pending <= expected_decodes.size();
		end
	end

endmodule

>>> bench/testbench.sv
// Top of the predecoder bench: clock, reset, fetch stimulus, decode back-pressure, verdict.
// Depends on atpd_pkg, the predecoder RTL and predecode_checker.
`timescale 1ns / 100ps

module testbench;
	import atpd_pkg::*;

	localparam int CLK_HALF        = 10;
	localparam int RESET_CYCLES    = 11;
	localparam int RANDOM_ITEMS    = 525;
	// The sender stops at this item and waits until every decode record is back.
	localparam int DRAIN_AT        = 330;
	// After this many records the receiver stalls for a long stretch so both stages fill.
	localparam int LONG_HOLD_AFTER = 150;
	localparam int LONG_HOLD_LEN   = 40;
	// Two pipeline stages, so the tail wait after the last record is enough to catch extras.
	localparam int TAIL_CYCLES     = 6;
	localparam int CYCLE_LIMIT     = 100000;

	logic    clk;
	logic    arst_n;
	logic    fetch_valid;
	logic    fetch_stall;
	fetch_t  fetch;
	logic    decode_valid;
	logic    decode_stall;
	decode_t decode;
	int      mismatches;
	int      pending;
	int      cycle_count = 0;

	arm_thumb_instruction_predecoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.fetch_valid  (fetch_valid),
		.fetch_stall  (fetch_stall),
		.fetch        (fetch),
		.decode_valid (decode_valid),
		.decode_stall (decode_stall),
		.decode       (decode)
	);

	predecode_checker decode_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.fetch_valid  (fetch_valid),
		.fetch_stall  (fetch_stall),
		.fetch        (fetch),
		.decode_valid (decode_valid),
		.decode_stall (decode_stall),
		.decode       (decode),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Hard stop in case the handshake hangs somewhere.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Builds a random fetch transaction. Most picks force one instruction class with
	// random content in its free bits, so each decoder path is reached often; the rest
	// are raw words in either mode. ARM classes that need a real condition get one.
	function automatic fetch_t random_fetch();
		fetch_t      f;
		logic [31:0] raw;
		logic [31:0] mask;
		logic [31:0] value;
		logic        needs_cond;
		int          pick;
		raw = $urandom;
		mask = '0;
		value = '0;
		needs_cond = 1'b0;
		f.thumb_mode = 1'b0;
		pick = $urandom_range(0, 27);
		case (pick)
			0: begin mask = 32'h0e000000; value = 32'h0a000000; needs_cond = 1'b1; end
			1: begin mask = 32'h0ffffff0; value = 32'h012fff10; needs_cond = 1'b1; end
			2: begin mask = 32'h0ffffff0; value = 32'h012fff30; needs_cond = 1'b1; end
			3: begin mask = 32'h0f000000; value = 32'h0f000000; needs_cond = 1'b1; end
			4: begin mask = 32'h0fc000f0; value = 32'h00000090; needs_cond = 1'b1; end
			5: begin mask = 32'h0f8000f0; value = 32'h00800090; needs_cond = 1'b1; end
			6: begin mask = 32'h0e000000; value = 32'h00000000; needs_cond = 1'b1; end
			7: begin mask = 32'h0e000000; value = 32'h02000000; needs_cond = 1'b1; end
			8: begin mask = 32'h0e200000; value = 32'h05000000; needs_cond = 1'b1; end
			9: begin mask = 32'h0c000000; value = 32'h04000000; needs_cond = 1'b1; end
			10: begin mask = 32'h0e000000; value = 32'h08000000; needs_cond = 1'b1; end
			11: begin mask = 32'hffffffff; value = 32'hf57ff01f; end
			12: begin mask = 32'hfc00f000; value = 32'hf400f000; end
			13: begin mask = 32'hfe000000; value = 32'hfa000000; end
			14: begin mask = 32'hfff1fe20; value = 32'hf1000000; end
			15, 16: begin end
			17: begin mask = 32'h0000e000; value = 32'h00002000; f.thumb_mode = 1'b1; end
			18: begin mask = 32'h0000e000; value = 32'h00000000; f.thumb_mode = 1'b1; end
			19: begin mask = 32'h0000f800; value = 32'h00001800; f.thumb_mode = 1'b1; end
			20: begin mask = 32'h0000fc00; value = 32'h00004000; f.thumb_mode = 1'b1; end
			21: begin mask = 32'h0000fc00; value = 32'h00004400; f.thumb_mode = 1'b1; end
			22: begin mask = 32'h0000f800; value = 32'h00004800; f.thumb_mode = 1'b1; end
			23: begin mask = 32'h0000e000; value = 32'h00006000; f.thumb_mode = 1'b1; end
			24: begin mask = 32'h0000f000; value = 32'h00009000; f.thumb_mode = 1'b1; end
			25: begin mask = 32'h0000f000; value = 32'h0000d000; f.thumb_mode = 1'b1; end
			26: begin mask = 32'h0000f800; value = 32'h0000e000; f.thumb_mode = 1'b1; end
			default: f.thumb_mode = 1'b1;
		endcase
		if (needs_cond && raw[31:28] == COND_NV) begin
			raw[31:28] = 4'($urandom_range(0, 14));
		end
		f.instruction_word = (raw & ~mask) | value;
		// Addresses near the top of memory make next PC and branch targets wrap.
		if ($urandom_range(0, 7) == 0) begin
			f.fetch_address = 32'hffffffff - $urandom_range(0, 15);
		end else begin
			f.fetch_address = $urandom;
		end
		return f;
	endfunction

	// Offers one fetch transaction after a random idle gap and returns at the edge
	// where it is accepted. During a quiet stretch the gap is always zero so that
	// transactions go back to back.
	task automatic offer_fetch(input fetch_t item, input logic quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			fetch_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fetch_valid <= 1'b1;
		fetch <= item;
		@(posedge clk);
		while (fetch_stall) @(posedge clk);
	endtask

	// Decode side: random stall before each record, quiet stretches without stalls,
	// and one long hold while the sender keeps offering so that fetch_stall must rise.
	initial begin : result_sink
		int gap;
		int taken;
		taken = 0;
		forever begin
			if (taken == LONG_HOLD_AFTER) begin
				gap = LONG_HOLD_LEN;
			end else if ((taken / 50) % 4 == 1) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 3);
			end
			if (gap > 0) begin
				decode_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			decode_stall <= 1'b0;
			@(posedge clk);
			while (!decode_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : fetch_source
		fetch_t directed_fetches[$];
		int     item_idx;
		arst_n <= 1'b0;
		fetch_valid <= 1'b0;
		fetch <= '0;

		// Directed part: field extremes, every ARM class, and the odd corners such as
		// partial fields on fallback transfers, the user-bank block transfer, plain
		// test/compare opcodes without S, ignored upper Thumb bits and address wrap.
		directed_fetches.push_back({32'h00000000, 32'he3a000ff, 1'b0});
		directed_fetches.push_back({32'h12345678, 32'he2911fff, 1'b0});
		directed_fetches.push_back({32'h00001000, 32'he0810312, 1'b0});
		directed_fetches.push_back({32'h00001004, 32'he1000001, 1'b0});
		directed_fetches.push_back({32'h00001008, 32'he01f0291, 1'b0});
		directed_fetches.push_back({32'h0000100c, 32'he0e0f192, 1'b0});
		directed_fetches.push_back({32'h00000000, 32'heafffffd, 1'b0});
		directed_fetches.push_back({32'hfffffffc, 32'h0b7fffff, 1'b0});
		directed_fetches.push_back({32'h80000000, 32'he12fff1e, 1'b0});
		directed_fetches.push_back({32'h7ffffffc, 32'h012fff33, 1'b0});
		directed_fetches.push_back({32'hffffffff, 32'hefffffff, 1'b0});
		directed_fetches.push_back({32'h00002000, 32'he51ff004, 1'b0});
		directed_fetches.push_back({32'h00002004, 32'he5c01fff, 1'b0});
		directed_fetches.push_back({32'h00002008, 32'he690f000, 1'b0});
		directed_fetches.push_back({32'h0000200c, 32'he8bd8000, 1'b0});
		directed_fetches.push_back({32'h00002010, 32'he8c00003, 1'b0});
		directed_fetches.push_back({32'h00002014, 32'hf57ff01f, 1'b0});
		directed_fetches.push_back({32'h00002018, 32'hf5d0f000, 1'b0});
		directed_fetches.push_back({32'h00000101, 32'hfbffffff, 1'b0});
		directed_fetches.push_back({32'h00002020, 32'hf10c0080, 1'b0});
		directed_fetches.push_back({32'h00002024, 32'hffffffff, 1'b0});
		directed_fetches.push_back({32'h00002028, 32'he1d000b0, 1'b0});
		directed_fetches.push_back({32'h00000000, 32'habcdd0fe, 1'b1});
		directed_fetches.push_back({32'h00003002, 32'hffffdeff, 1'b1});
		directed_fetches.push_back({32'hfffffffe, 32'h0000e400, 1'b1});
		directed_fetches.push_back({32'h00003006, 32'h000046f7, 1'b1});
		directed_fetches.push_back({32'h00003008, 32'h55554100, 1'b1});

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_fetches[i]) begin
			offer_fetch(directed_fetches[i], 1'b0);
		end

		for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
			if (item_idx == DRAIN_AT) begin
				// Let the pipeline run completely dry before carrying on.
				fetch_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			offer_fetch(random_fetch(), (item_idx / 60) % 4 == 2);
		end

		fetch_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
